// File: rtl/pdq_pkg.sv
// Package for the priority dispatch queue: field widths, operation and
// status codes, controller state type and controller/datapath structs.
// No dependencies.
package pdq_pkg;

  localparam int ID_W  = 8;
  localparam int PRI_W = 4;
  localparam int OCC_W = 5;
  localparam int ST_W  = 2;

  // Item kind codes
  localparam logic KIND_CREATE   = 1'b0;
  localparam logic KIND_DISPATCH = 1'b1;

  // Result status codes
  localparam logic [ST_W-1:0] ST_CREATED    = 2'd0;
  localparam logic [ST_W-1:0] ST_DISPATCHED = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL       = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY      = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;       // capture the input transaction
    logic create;      // store new task and load a created result
    logic load_full;   // load a full result
    logic load_empty;  // load an empty result
    logic scan_init;   // restart the best-entry search
    logic scan_run;    // advance the best-entry search
    logic shift_init;  // start compaction just above the best entry
    logic shift_run;   // advance compaction
    logic load_disp;   // drop one task and load a dispatched result
  } pdq_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_dispatch;
    logic full;
    logic empty;
    logic out_free;
    logic run_done;
  } pdq_stat_t;

endpackage

// File: rtl/priority_dispatch_queue_top.sv
// Top level of the priority dispatch queue: controller plus datapath.
// Depends on pdq_pkg, pdq_ctrl and pdq_datapath.
//
//   channel | signals                                      | direction
//   --------+----------------------------------------------+----------
//   input   | in_valid, in_ready, kind, priority_req       | in
//   result  | out_valid, out_ready, status, task_id,       | out
//           | task_priority, occupancy                     |
//
// One transaction in flight at a time. Create, full and empty are accepted,
// then loaded into the output register. A dispatch with tasks held, best at
// slot B, runs a linear search over the single read port of the task memory,
// then compaction of the slots above B, then its load.
// Reset clears the counters, the controller and the output valid.
// A stalled result holds in the output register; the next transaction is
// accepted meanwhile and waits before its load for the register to free.
module priority_dispatch_queue_top import pdq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             kind,
  input  logic [PRI_W-1:0] priority_req,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ST_W-1:0]  status,
  output logic [ID_W-1:0]  task_id,
  output logic [PRI_W-1:0] task_priority,
  output logic [OCC_W-1:0] occupancy
);

  pdq_cmd_t  cmd;
  pdq_stat_t stat;

  pdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .kind          (kind),
    .priority_req  (priority_req),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .status        (status),
    .task_id       (task_id),
    .task_priority (task_priority),
    .occupancy     (occupancy)
  );

endmodule

// File: rtl/pdq_datapath.sv
// Datapath of the priority dispatch queue: task memory, counters,
// best-entry search, compaction and the output register.
// Depends on pdq_pkg.
module pdq_datapath import pdq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  pdq_cmd_t         cmd,
  output pdq_stat_t        stat,
  input  logic             kind,
  input  logic [PRI_W-1:0] priority_req,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [ST_W-1:0]  status,
  output logic [ID_W-1:0]  task_id,
  output logic [PRI_W-1:0] task_priority,
  output logic [OCC_W-1:0] occupancy
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [ID_W-1:0]  mem_id  [DEPTH];
  logic [PRI_W-1:0] mem_pri [DEPTH];

  logic [CW-1:0]    held_count;
  logic [ID_W-1:0]  next_id;
  logic             in_kind;
  logic [PRI_W-1:0] in_pri;
  logic [CW-1:0]    ptr;
  logic             rd_pend;
  logic [AW-1:0]    rd_from;
  logic [ID_W-1:0]  rd_id;
  logic [PRI_W-1:0] rd_pri;
  logic             have_best;
  logic [AW-1:0]    best_idx;
  logic [ID_W-1:0]  best_id;
  logic [PRI_W-1:0] best_pri;

  logic [ST_W-1:0]  out_status;
  logic [ID_W-1:0]  out_id;
  logic [PRI_W-1:0] out_pri;
  logic [OCC_W-1:0] out_occ;

  logic             rd_en;
  logic             wr_en;
  logic [AW-1:0]    waddr;
  logic [ID_W-1:0]  wid;
  logic [PRI_W-1:0] wpri;
  logic             take;
  logic             any_load;

  // Memory port control
  always_comb begin
    rd_en    = (cmd.scan_run | cmd.shift_run) & (ptr < held_count);
    wr_en    = cmd.create | (cmd.shift_run & rd_pend);
    waddr    = cmd.create ? held_count[AW-1:0] : rd_from - 1'b1;
    wid      = cmd.create ? next_id : rd_id;
    wpri     = cmd.create ? in_pri : rd_pri;
    take     = !have_best || (rd_pri > best_pri);
    any_load = cmd.create | cmd.load_full | cmd.load_empty | cmd.load_disp;
  end

  // Task memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id[waddr]  <= wid;
      mem_pri[waddr] <= wpri;
    end
    if (rd_en) begin
      rd_id  <= mem_id[ptr[AW-1:0]];
      rd_pri <= mem_pri[ptr[AW-1:0]];
    end
  end

  // Control counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      next_id    <= '0;
      rd_pend    <= 1'b0;
      have_best  <= 1'b0;
      ptr        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.create) begin
        held_count <= held_count + 1'b1;
        next_id    <= next_id + 1'b1;
      end else if (cmd.load_disp) begin
        held_count <= held_count - 1'b1;
      end

      if (cmd.scan_init) begin
        ptr <= '0;
      end else if (cmd.shift_init) begin
        ptr <= CW'(best_idx) + 1'b1;
      end else if (rd_en) begin
        ptr <= ptr + 1'b1;
      end

      if (cmd.scan_init || cmd.shift_init) begin
        rd_pend <= 1'b0;
      end else if (cmd.scan_run || cmd.shift_run) begin
        rd_pend <= rd_en;
      end

      if (cmd.scan_init) begin
        have_best <= 1'b0;
      end else if (cmd.scan_run && rd_pend) begin
        have_best <= 1'b1;
      end

      if (any_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Input capture, search registers and result payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_kind <= kind;
      in_pri  <= priority_req;
    end
    if (rd_en) begin
      rd_from <= ptr[AW-1:0];
    end
    // Keep the first of equal priorities: replace only on strictly greater
    if (cmd.scan_run && rd_pend && take) begin
      best_idx <= rd_from;
      best_id  <= rd_id;
      best_pri <= rd_pri;
    end
    if (cmd.create) begin
      out_status <= ST_CREATED;
      out_id     <= next_id;
      out_pri    <= in_pri;
      out_occ    <= OCC_W'(held_count + 1'b1);
    end else if (cmd.load_disp) begin
      out_status <= ST_DISPATCHED;
      out_id     <= best_id;
      out_pri    <= best_pri;
      out_occ    <= OCC_W'(held_count - 1'b1);
    end else if (cmd.load_full) begin
      out_status <= ST_FULL;
      out_id     <= '0;
      out_pri    <= '0;
      out_occ    <= OCC_W'(held_count);
    end else if (cmd.load_empty) begin
      out_status <= ST_EMPTY;
      out_id     <= '0;
      out_pri    <= '0;
      out_occ    <= OCC_W'(held_count);
    end
  end

  // Status to the controller
  always_comb begin
    stat.is_dispatch = (in_kind == KIND_DISPATCH);
    stat.full        = (held_count == CW'(DEPTH));
    stat.empty       = (held_count == '0);
    stat.out_free    = !out_valid || out_ready;
    stat.run_done    = !rd_pend && (ptr >= held_count);
  end

  assign status        = out_status;
  assign task_id       = out_id;
  assign task_priority = out_pri;
  assign occupancy     = out_occ;

endmodule

// File: rtl/pdq_ctrl.sv
// Controller of the priority dispatch queue: sequences accept, search,
// compaction and result load.
// Depends on pdq_pkg.
module pdq_ctrl import pdq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  pdq_stat_t stat,
  output pdq_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.is_dispatch && !stat.empty) begin
          state_next = S_SCAN;
        end else if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.run_done) state_next = S_SHIFT;
      end
      S_SHIFT: begin
        if (stat.run_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_EXEC: begin
        if (stat.is_dispatch) begin
          if (!stat.empty) begin
            cmd.scan_init = 1'b1;
          end else begin
            cmd.load_empty = stat.out_free;
          end
        end else if (stat.full) begin
          cmd.load_full = stat.out_free;
        end else begin
          cmd.create = stat.out_free;
        end
      end
      S_SCAN: begin
        if (stat.run_done) begin
          cmd.shift_init = 1'b1;
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.shift_run = !stat.run_done;
      end
      S_EMIT: begin
        cmd.load_disp = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
